### hdl/qct_pkg.sv
// shared types and character codes for the quoted command tokenizer
`timescale 1ns / 1ps

package qct_pkg;

  localparam int ByteW = 8;
  localparam int OutDataW = 16;

  localparam logic [ByteW-1:0] CH_NL    = 8'h0A;
  localparam logic [ByteW-1:0] CH_QUOTE = 8'h22;
  localparam logic [ByteW-1:0] CH_BSL   = 8'h5C;
  localparam logic [ByteW-1:0] CH_SP    = 8'h20;
  localparam logic [ByteW-1:0] CH_N     = 8'h6E;

  typedef enum logic [5:0] {
    ST_BEGIN        = 6'b000001,
    ST_QUOTED       = 6'b000010,
    ST_UNQUOTED     = 6'b000100,
    ST_UNQUOTED_ESC = 6'b001000,
    ST_QUOTED_ESC   = 6'b010000,
    ST_ERROR        = 6'b100000
  } parse_state_t;

  typedef struct packed {
    logic             byte_valid;
    logic [ByteW-1:0] token_byte;
    logic             token_end;
    logic             command_end;
    logic             command_error;
  } result_t;

endpackage

### hdl/qct_in_stage.sv
// input register for one character beat
`timescale 1ns / 1ps

module qct_in_stage (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [qct_pkg::ByteW-1:0] s_byte,
  input  logic                     take,
  output logic                     hold_valid,
  output logic [qct_pkg::ByteW-1:0] hold_byte
);

  // slot frees up in the same cycle the parser takes the held byte
  assign s_tready = !hold_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      hold_valid <= 1'b1;
    end else if (take) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      hold_byte <= s_byte;
    end
  end

endmodule

### hdl/qct_parser.sv
// parse state machine deciding one character per cycle while the result register can take a beat
`timescale 1ns / 1ps

module qct_parser (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      hold_valid,
  input  logic [qct_pkg::ByteW-1:0] hold_byte,
  input  logic                      out_free,
  output logic                      take,
  output logic                      res_valid,
  output qct_pkg::result_t          res
);

  qct_pkg::parse_state_t state;
  qct_pkg::parse_state_t state_next;

  qct_pkg::parse_state_t unq_state;
  logic                  unq_emit;
  qct_pkg::result_t      unq_res;

  logic                      esc_ok;
  logic [qct_pkg::ByteW-1:0] esc_byte;
  logic                      emit;

  assign take = hold_valid && out_free;
  assign res_valid = take && emit;

  // byte inside, or starting, an unquoted token
  always_comb begin
    unq_res = '0;
    unq_emit = 1'b1;
    unq_state = qct_pkg::ST_UNQUOTED;
    if (hold_byte == qct_pkg::CH_SP) begin
      unq_state = qct_pkg::ST_BEGIN;
      unq_res.token_end = 1'b1;
    end else if (hold_byte == qct_pkg::CH_NL) begin
      unq_state = qct_pkg::ST_BEGIN;
      unq_res.token_end = 1'b1;
      unq_res.command_end = 1'b1;
    end else if (hold_byte == qct_pkg::CH_BSL) begin
      unq_state = qct_pkg::ST_UNQUOTED_ESC;
      unq_emit = 1'b0;
    end else begin
      unq_res.byte_valid = 1'b1;
      unq_res.token_byte = hold_byte;
    end
  end

  // escape decoding: n, space, backslash
  always_comb begin
    esc_ok = (hold_byte == qct_pkg::CH_N) || (hold_byte == qct_pkg::CH_SP) ||
             (hold_byte == qct_pkg::CH_BSL);
    esc_byte = (hold_byte == qct_pkg::CH_N) ? qct_pkg::CH_NL : hold_byte;
  end

  always_comb begin
    state_next = state;
    emit = 1'b0;
    res = '0;
    case (state)
      qct_pkg::ST_QUOTED: begin
        if (hold_byte == qct_pkg::CH_QUOTE) begin
          state_next = qct_pkg::ST_BEGIN;
          emit = 1'b1;
          res.token_end = 1'b1;
        end else if (hold_byte == qct_pkg::CH_BSL) begin
          state_next = qct_pkg::ST_QUOTED_ESC;
        end else if (hold_byte == qct_pkg::CH_NL) begin
          state_next = qct_pkg::ST_BEGIN;
          emit = 1'b1;
          res.command_end = 1'b1;
          res.command_error = 1'b1;
        end else begin
          emit = 1'b1;
          res.byte_valid = 1'b1;
          res.token_byte = hold_byte;
        end
      end
      qct_pkg::ST_UNQUOTED: begin
        state_next = unq_state;
        emit = unq_emit;
        res = unq_res;
      end
      qct_pkg::ST_UNQUOTED_ESC, qct_pkg::ST_QUOTED_ESC: begin
        if (esc_ok) begin
          state_next = (state == qct_pkg::ST_QUOTED_ESC) ? qct_pkg::ST_QUOTED
                                                          : qct_pkg::ST_UNQUOTED;
          emit = 1'b1;
          res.byte_valid = 1'b1;
          res.token_byte = esc_byte;
        end else begin
          state_next = qct_pkg::ST_ERROR;
        end
      end
      qct_pkg::ST_ERROR: begin
        if (hold_byte == qct_pkg::CH_NL) begin
          state_next = qct_pkg::ST_BEGIN;
          emit = 1'b1;
          res.command_end = 1'b1;
          res.command_error = 1'b1;
        end
      end
      default: begin
        // between tokens
        if (hold_byte == qct_pkg::CH_SP) begin
          state_next = qct_pkg::ST_BEGIN;
        end else if (hold_byte == qct_pkg::CH_NL) begin
          state_next = qct_pkg::ST_BEGIN;
          emit = 1'b1;
          res.command_end = 1'b1;
        end else if (hold_byte == qct_pkg::CH_QUOTE) begin
          state_next = qct_pkg::ST_QUOTED;
        end else begin
          state_next = unq_state;
          emit = unq_emit;
          res = unq_res;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qct_pkg::ST_BEGIN;
    end else if (take) begin
      state <= state_next;
    end
  end

  // error flag only rides on a line end
  a_err_with_end: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.command_error |-> res.command_end)
    else $error("command_error without command_end");

  // a token byte never closes the token in the same beat
  a_byte_not_end: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.byte_valid |-> !res.token_end && !res.command_end)
    else $error("token byte combined with end flag");

  // unescaped newline always returns to between tokens
  a_nl_to_begin: assert property (@(posedge clk) disable iff (rst)
    take && hold_byte == qct_pkg::CH_NL && state != qct_pkg::ST_UNQUOTED_ESC &&
    state != qct_pkg::ST_QUOTED_ESC |=> state == qct_pkg::ST_BEGIN)
    else $error("newline did not end the line");

  // no result without a taken input
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !take |-> !res_valid)
    else $error("result without input");

endmodule

### hdl/qct_out_stage.sv
// result register toward the master side
`timescale 1ns / 1ps

module qct_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             res_valid,
  input  qct_pkg::result_t res,
  output logic             out_free,
  output logic             m_tvalid,
  input  logic             m_tready,
  output qct_pkg::result_t m_res
);

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_res <= res;
    end
  end

endmodule

### hdl/quoted_command_tokenizer_top.sv
// Shell-style command line tokenizer: takes one character per beat on the
// slave side and streams decoded token characters with end markers on the
// master side. Tokens are split on spaces and may be double-quoted; a
// backslash escape accepts n (newline), space or backslash. A bad escape or
// a newline inside quotes marks the line in error until its newline, which
// then comes out with tlast and tuser high; the consumer drops that line.
// Throughput is one character per clock cycle while the master side keeps up,
// set by the parse state machine between the input register and the result
// register. An accepted character is held in the input register and its result
// in the result register; while the result register waits on tready the input holds off.
// Characters that make no result (separator spaces, opening quotes, backslashes,
// skipped bytes of a bad line) produce no master beat at all.
`timescale 1ns / 1ps

module quoted_command_tokenizer_top (
  input  logic                         clk,
  input  logic                         rst,
  // slave side, tdata: in_byte [7:0]
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [qct_pkg::ByteW-1:0]    s_tdata,
  // master side, tdata: byte_valid [0], token_byte [8:1], token_end [9],
  // zero fill [15:10]
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [qct_pkg::OutDataW-1:0] m_tdata,
  // command_end
  output logic                         m_tlast,
  // command_error
  output logic                         m_tuser
);

  // held character between input register and parser
  logic                      hold_valid;
  logic [qct_pkg::ByteW-1:0] hold_byte;

  // handshake between parser and result register
  logic             take;
  logic             out_free;
  logic             res_valid;
  qct_pkg::result_t res;
  qct_pkg::result_t m_res;

  qct_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_byte     (s_tdata),
    .take       (take),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte)
  );

  // decides the held character when the result register can take a beat
  qct_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte),
    .out_free   (out_free),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res)
  );

  qct_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_res     (m_res)
  );

  // pack result fields, lowest bit first, zero filled to whole bytes
  assign m_tdata = {{(qct_pkg::OutDataW - qct_pkg::ByteW - 2){1'b0}},
                    m_res.token_end, m_res.token_byte, m_res.byte_valid};
  assign m_tlast = m_res.command_end;
  assign m_tuser = m_res.command_error;

endmodule

### dv/quoted_command_tokenizer_top_tb.sv
// self-checking testbench for the quoted command tokenizer: directed lines, then random lines
`timescale 1ns / 1ps

module quoted_command_tokenizer_top_tb;

  localparam int IdleLimit = 2000;  // cycles with no beat on either side
  localparam int LongHold  = 100;   // long receiver stall
  localparam int RandItems = 700;

  // tracks the parse state of the block and holds the result beats still owed
  class tokenizer_scoreboard;
    qct_pkg::parse_state_t state;
    qct_pkg::result_t      owed_q[$];
    int errors, checked, tokens, lines, bad_lines;

    function new();
      state = qct_pkg::ST_BEGIN;
    endfunction

    function bit skipping();
      return state == qct_pkg::ST_ERROR;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // byte inside an unquoted token, or the first byte of one
    function void plain_char(input logic [7:0] c, inout qct_pkg::result_t r, inout bit has);
      if (c == qct_pkg::CH_SP) begin
        state = qct_pkg::ST_BEGIN;
        r.token_end = 1'b1;
        has = 1'b1;
      end else if (c == qct_pkg::CH_NL) begin
        state = qct_pkg::ST_BEGIN;
        r.token_end = 1'b1;
        r.command_end = 1'b1;
        has = 1'b1;
      end else if (c == qct_pkg::CH_BSL) begin
        state = qct_pkg::ST_UNQUOTED_ESC;
      end else begin
        state = qct_pkg::ST_UNQUOTED;
        r.byte_valid = 1'b1;
        r.token_byte = c;
        has = 1'b1;
      end
    endfunction

    // byte after a backslash; only n, space and backslash are legal
    function void escaped(input logic [7:0] c, input qct_pkg::parse_state_t back,
                          inout qct_pkg::result_t r, inout bit has);
      if (c == qct_pkg::CH_N || c == qct_pkg::CH_SP || c == qct_pkg::CH_BSL) begin
        state = back;
        r.byte_valid = 1'b1;
        r.token_byte = (c == qct_pkg::CH_N) ? qct_pkg::CH_NL : c;
        has = 1'b1;
      end else begin
        state = qct_pkg::ST_ERROR;
      end
    endfunction

    // accepted input beat: advance the parse state, queue the result it causes
    function void note_byte(input logic [7:0] c);
      qct_pkg::result_t r;
      bit has;
      r = '0;
      has = 1'b0;
      case (state)
        qct_pkg::ST_QUOTED: begin
          if (c == qct_pkg::CH_QUOTE) begin
            state = qct_pkg::ST_BEGIN;
            r.token_end = 1'b1;
            has = 1'b1;
          end else if (c == qct_pkg::CH_BSL) begin
            state = qct_pkg::ST_QUOTED_ESC;
          end else if (c == qct_pkg::CH_NL) begin
            state = qct_pkg::ST_BEGIN;
            r.command_end = 1'b1;
            r.command_error = 1'b1;
            has = 1'b1;
          end else begin
            r.byte_valid = 1'b1;
            r.token_byte = c;
            has = 1'b1;
          end
        end
        qct_pkg::ST_UNQUOTED:     plain_char(c, r, has);
        qct_pkg::ST_UNQUOTED_ESC: escaped(c, qct_pkg::ST_UNQUOTED, r, has);
        qct_pkg::ST_QUOTED_ESC:   escaped(c, qct_pkg::ST_QUOTED, r, has);
        qct_pkg::ST_ERROR: begin
          if (c == qct_pkg::CH_NL) begin
            state = qct_pkg::ST_BEGIN;
            r.command_end = 1'b1;
            r.command_error = 1'b1;
            has = 1'b1;
          end
        end
        default: begin
          if (c == qct_pkg::CH_SP) begin
            state = qct_pkg::ST_BEGIN;
          end else if (c == qct_pkg::CH_NL) begin
            state = qct_pkg::ST_BEGIN;
            r.command_end = 1'b1;
            has = 1'b1;
          end else if (c == qct_pkg::CH_QUOTE) begin
            state = qct_pkg::ST_QUOTED;
          end else begin
            plain_char(c, r, has);
          end
        end
      endcase
      if (has) begin
        owed_q = {owed_q, r};
        if (r.token_end) tokens++;
        if (r.command_end) lines++;
        if (r.command_error) bad_lines++;
      end
    endfunction

    function void diff(input string field, input int want, input int got);
      if (want != got) begin
        errors++;
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    // accepted result beat: compare with the oldest owed result
    function void check_result(input qct_pkg::result_t got);
      qct_pkg::result_t want;
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected beat, expected none, actual %h", $time, got);
        return;
      end
      want = owed_q.pop_front();
      checked++;
      diff("byte_valid", int'(want.byte_valid), int'(got.byte_valid));
      diff("token_byte", int'(want.token_byte), int'(got.token_byte));
      diff("token_end", int'(want.token_end), int'(got.token_end));
      diff("command_end", int'(want.command_end), int'(got.command_end));
      diff("command_error", int'(want.command_error), int'(got.command_error));
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [qct_pkg::ByteW-1:0]    s_tdata = '0;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [qct_pkg::OutDataW-1:0] m_tdata;
  logic                         m_tlast;
  logic                         m_tuser;

  tokenizer_scoreboard sb = new();

  int bytes_sent = 0;
  int live_items = 0;   // bytes not swallowed by a line in error
  int tx_calm = 0;
  int rx_calm = 0;
  bit tx_rush = 1'b0;
  bit rx_hold_req = 1'b0;
  int idle_cycles = 0;

  quoted_command_tokenizer_top DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
  );

  always #4 clk = ~clk;

  // idle cycles before the next beat; now and then a run of back-to-back beats
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 9);
  endfunction

  // byte that is plain content of a token; spaces only inside quotes
  function automatic logic [7:0] token_char(input bit quoted);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == qct_pkg::CH_NL || c == qct_pkg::CH_QUOTE || c == qct_pkg::CH_BSL ||
           (c == qct_pkg::CH_SP && !quoted));
    return c;
  endfunction

  task automatic send_byte(input logic [7:0] c);
    int gap;
    gap = tx_rush ? 0 : draw_gap(tx_calm);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= c;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
    if (!sb.skipping()) live_items++;
    sb.note_byte(c);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // drop valid and wait for every owed result
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() > 0);
  endtask

  // a command line of random tokens, sometimes broken by a bad escape
  // or a newline inside quotes
  task automatic send_line();
    int ntok;
    int len;
    bit quoted;
    logic [7:0] c;
    ntok = $urandom_range(0, 4);
    repeat ($urandom_range(0, 1)) send_byte(qct_pkg::CH_SP);
    for (int t = 0; t < ntok; t++) begin
      if (t > 0) repeat ($urandom_range(1, 2)) send_byte(qct_pkg::CH_SP);
      quoted = ($urandom_range(0, 2) == 0);
      if (quoted) send_byte(qct_pkg::CH_QUOTE);
      len = $urandom_range(quoted ? 0 : 1, 6);
      for (int k = 0; k < len; k++) begin
        case ($urandom_range(0, 39))
          0: begin
            // bad escape, which may itself be a newline, then junk
            send_byte(qct_pkg::CH_BSL);
            if ($urandom_range(0, 3) == 0) begin
              c = qct_pkg::CH_NL;
            end else begin
              do c = 8'($urandom_range(0, 255));
              while (c == qct_pkg::CH_N || c == qct_pkg::CH_SP || c == qct_pkg::CH_BSL);
            end
            send_byte(c);
            repeat ($urandom_range(0, 4)) send_byte(token_char(1'b1));
            send_byte(qct_pkg::CH_NL);
            return;
          end
          1: begin
            if (quoted) begin
              send_byte(qct_pkg::CH_NL);
              return;
            end
            send_byte(token_char(quoted));
          end
          2, 3, 4, 5, 6: begin
            send_byte(qct_pkg::CH_BSL);
            case ($urandom_range(0, 2))
              0: send_byte(qct_pkg::CH_N);
              1: send_byte(qct_pkg::CH_SP);
              default: send_byte(qct_pkg::CH_BSL);
            endcase
          end
          default: send_byte(token_char(quoted));
        endcase
      end
      if (quoted) send_byte(qct_pkg::CH_QUOTE);
    end
    if ($urandom_range(0, 3) == 0) send_byte(qct_pkg::CH_SP);
    send_byte(qct_pkg::CH_NL);
  endtask

  // raw bytes biased toward the special characters
  task automatic send_noise();
    repeat ($urandom_range(1, 12)) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 4))
          0: send_byte(qct_pkg::CH_NL);
          1: send_byte(qct_pkg::CH_QUOTE);
          2: send_byte(qct_pkg::CH_BSL);
          3: send_byte(qct_pkg::CH_SP);
          default: send_byte(qct_pkg::CH_N);
        endcase
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
    send_byte(qct_pkg::CH_NL);
  endtask

  // receiver stalls for a long time while a back-to-back token streams in,
  // so the pipeline fills and input backpressure shows up
  task automatic stall_burst();
    send_byte(qct_pkg::CH_NL);
    send_byte(qct_pkg::CH_NL);
    rx_hold_req = 1'b1;
    tx_rush = 1'b1;
    repeat (24) send_byte(token_char(1'b0));
    send_byte(qct_pkg::CH_NL);
    tx_rush = 1'b0;
  endtask

  // result side: random tready with occasional long hold-off
  initial begin : result_sink
    int gap;
    qct_pkg::result_t got;
    do @(posedge clk); while (rst);
    forever begin
      if (rx_hold_req) begin
        m_tready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        rx_hold_req = 1'b0;
      end
      gap = draw_gap(rx_calm);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got.byte_valid    = m_tdata[0];
      got.token_byte    = m_tdata[8:1];
      got.token_end     = m_tdata[9];
      got.command_end   = m_tlast;
      got.command_error = m_tuser;
      sb.check_result(got);
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
          $display("%0t ns: no beat for %0d cycles, %0d results owed", $time, idle_cycles,
                   sb.pending());
          $display("quoted_command_tokenizer_top verification failed");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    bit did_hold;
    bit did_drain;
    did_hold = 1'b0;
    did_drain = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: separators, quotes, every escape, both newline errors,
    // a newline after a backslash, all-ones and all-zeros bytes
    send_text("a \"b\\n\" \n");
    send_text("\\ \\\\\n");
    send_text("\"x\n");
    send_text("\\\n");
    send_byte(8'hFF);
    send_byte(qct_pkg::CH_NL);
    send_byte(8'h00);
    send_byte(qct_pkg::CH_NL);

    live_items = 0;
    while (live_items < RandItems) begin
      if ($urandom_range(0, 7) == 0) send_noise();
      else send_line();
      if (!did_hold && live_items > 200) begin
        stall_burst();
        did_hold = 1'b1;
      end
      if (!did_drain && live_items > 450) begin
        drain();
        did_drain = 1'b1;
      end
    end

    drain();
    repeat (12) @(posedge clk);

    $display("sent %0d bytes; checked %0d result beats", bytes_sent, sb.checked);
    $display("covered %0d tokens over %0d lines, %0d of them malformed", sb.tokens, sb.lines,
             sb.bad_lines);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("quoted_command_tokenizer_top verification clean");
    end else begin
      $display("%0d mismatches, %0d results never arrived", sb.errors, sb.pending());
      $display("quoted_command_tokenizer_top verification failed");
    end
    $finish;
  end

endmodule
